// ----- rtl/delta_modulation_sample_channel_defines.svh -----
// Assertion macros shared by the delta-modulation sample channel RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DELTA_MODULATION_SAMPLE_CHANNEL_DEFINES_SVH
`define DELTA_MODULATION_SAMPLE_CHANNEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/dmc_pkg.sv -----
// Types, constants and the rate table of the delta-modulation sample channel.
// Depends on nothing; used by the core and the top level.
`default_nettype none

package dmc_pkg;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_REG_WRITE = 3'd1,
      OP_STATUS    = 3'd2,
      OP_DMA_DATA  = 3'd3,
      OP_IRQ_ACK   = 3'd4,
      OP_ENABLE    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      REG_FLAGS   = 2'd0,
      REG_LEVEL   = 2'd1,
      REG_ADDRESS = 2'd2,
      REG_LENGTH  = 2'd3
   } reg_select_type;

   localparam logic [15:0] ADDR_BASE     = 16'hC000;
   localparam logic [15:0] ADDR_WRAP     = 16'h8000;
   localparam logic [15:0] ADDR_LAST     = 16'hFFFF;
   localparam logic [6:0]  LEVEL_TOP     = 7'd125;
   localparam logic [6:0]  LEVEL_STEP    = 7'd2;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
   localparam logic [8:0]  PERIOD_RESET  = 9'd428;

   typedef struct packed {
      opcode_type  opcode;
      logic [1:0]  reg_select;
      logic [7:0]  write_value;
      logic [7:0]  dma_data;
      logic        enable_bit;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  level_out;
      logic        irq_out;
      logic        dma_request;
      logic [15:0] dma_address;
      logic [7:0]  read_data;
   } rsp_item_type;

   function automatic logic [8:0] rate_period(input logic [3:0] sel);
      logic [8:0] p;
      case (sel)
         4'd0:  p = 9'd428;
         4'd1:  p = 9'd380;
         4'd2:  p = 9'd340;
         4'd3:  p = 9'd320;
         4'd4:  p = 9'd286;
         4'd5:  p = 9'd254;
         4'd6:  p = 9'd226;
         4'd7:  p = 9'd214;
         4'd8:  p = 9'd190;
         4'd9:  p = 9'd160;
         4'd10: p = 9'd142;
         4'd11: p = 9'd128;
         4'd12: p = 9'd106;
         4'd13: p = 9'd84;
         4'd14: p = 9'd72;
         default: p = 9'd54;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dmc_req_if.sv -----
// Request channel of the delta-modulation sample channel: valid, ready and item fields.
// Depends on nothing.
`default_nettype none

interface dmc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [1:0] reg_select;
   logic [7:0] write_value;
   logic [7:0] dma_data;
   logic       enable_bit;

   modport source (output valid, opcode, reg_select, write_value, dma_data, enable_bit,
                   input ready);
   modport sink (input valid, opcode, reg_select, write_value, dma_data, enable_bit,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/dmc_rsp_if.sv -----
// Response channel of the delta-modulation sample channel: valid, ready and result fields.
// Depends on nothing.
`default_nettype none

interface dmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  level_out;
   logic        irq_out;
   logic        dma_request;
   logic [15:0] dma_address;
   logic [7:0]  read_data;

   modport source (output valid, level_out, irq_out, dma_request, dma_address, read_data,
                   input ready);
   modport sink (input valid, level_out, irq_out, dma_request, dma_address, read_data,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/dmc_core.sv -----
// Channel state and its one-step update: rate timer, shifter, sample buffer and DMA logic.
// Depends on dmc_pkg and the assertion macros in the defines header.
`default_nettype none
`include "delta_modulation_sample_channel_defines.svh"

module dmc_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire dmc_pkg::req_item_type item,
   output dmc_pkg::rsp_item_type      result
);

   logic        irq_enabled_ff, irq_enabled_in;
   logic        loop_mode_ff, loop_mode_in;
   logic [8:0]  period_value_ff, period_value_in;
   logic [8:0]  period_count_ff, period_count_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [11:0] start_length_ff, start_length_in;
   logic [15:0] fetch_address_ff, fetch_address_in;
   logic [11:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  buffer_byte_ff, buffer_byte_in;
   logic        buffer_empty_ff, buffer_empty_in;
   logic [7:0]  shift_bits_ff, shift_bits_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic [6:0]  level_ff, level_in;
   logic        fetch_pending_ff, fetch_pending_in;
   logic [15:0] pending_address_ff, pending_address_in;
   logic        channel_on_ff, channel_on_in;
   logic        irq_pending_ff, irq_pending_in;
   logic        silent_ff, silent_in;
   logic [7:0]  read_data;

   always_comb begin
      irq_enabled_in     = irq_enabled_ff;
      loop_mode_in       = loop_mode_ff;
      period_value_in    = period_value_ff;
      period_count_in    = period_count_ff;
      start_address_in   = start_address_ff;
      start_length_in    = start_length_ff;
      fetch_address_in   = fetch_address_ff;
      bytes_left_in      = bytes_left_ff;
      buffer_byte_in     = buffer_byte_ff;
      buffer_empty_in    = buffer_empty_ff;
      shift_bits_in      = shift_bits_ff;
      bits_left_in       = bits_left_ff;
      level_in           = level_ff;
      fetch_pending_in   = fetch_pending_ff;
      pending_address_in = pending_address_ff;
      channel_on_in      = channel_on_ff;
      irq_pending_in     = irq_pending_ff;
      silent_in          = silent_ff;
      read_data          = 8'h00;

      case (item.opcode)
         dmc_pkg::OP_TICK: begin
            if (channel_on_ff) begin
               if (period_count_in != 9'd0) begin
                  period_count_in = period_count_in - 9'd1;
               end
               if (period_count_in == 9'd0) begin
                  period_count_in = period_value_ff;
                  if (!silent_ff) begin
                     if (shift_bits_ff[0]) begin
                        if (level_ff <= dmc_pkg::LEVEL_TOP) begin
                           level_in = level_ff + dmc_pkg::LEVEL_STEP;
                        end
                     end else if (level_ff >= dmc_pkg::LEVEL_STEP) begin
                        level_in = level_ff - dmc_pkg::LEVEL_STEP;
                     end
                     shift_bits_in = {1'b0, shift_bits_ff[7:1]};
                  end
                  bits_left_in = bits_left_ff - 4'd1;
                  if (bits_left_in == 4'd0) begin
                     bits_left_in = dmc_pkg::BITS_PER_BYTE;
                     if (buffer_empty_ff) begin
                        silent_in = 1'b1;
                     end else begin
                        silent_in       = 1'b0;
                        shift_bits_in   = buffer_byte_ff;
                        buffer_empty_in = 1'b1;
                        if (bytes_left_ff != 12'd0) begin
                           fetch_pending_in   = 1'b1;
                           pending_address_in = fetch_address_ff;
                        end
                     end
                  end
               end
               if (buffer_empty_in && bytes_left_ff != 12'd0 && !fetch_pending_in) begin
                  fetch_pending_in   = 1'b1;
                  pending_address_in = fetch_address_ff;
               end
            end
         end
         dmc_pkg::OP_REG_WRITE: begin
            unique case (dmc_pkg::reg_select_type'(item.reg_select))
               dmc_pkg::REG_FLAGS: begin
                  irq_enabled_in  = item.write_value[7];
                  loop_mode_in    = item.write_value[6];
                  period_value_in = dmc_pkg::rate_period(item.write_value[3:0]);
                  if (!item.write_value[7]) begin
                     irq_pending_in = 1'b0;
                  end
               end
               dmc_pkg::REG_LEVEL: begin
                  level_in = item.write_value[6:0];
               end
               dmc_pkg::REG_ADDRESS: begin
                  start_address_in = dmc_pkg::ADDR_BASE | {2'b00, item.write_value, 6'd0};
               end
               dmc_pkg::REG_LENGTH: begin
                  start_length_in = {item.write_value, 4'b0001};
               end
            endcase
         end
         dmc_pkg::OP_STATUS: begin
            read_data = {irq_pending_ff, 6'd0, bytes_left_ff != 12'd0};
         end
         dmc_pkg::OP_DMA_DATA: begin
            buffer_byte_in   = item.dma_data;
            buffer_empty_in  = 1'b0;
            fetch_pending_in = 1'b0;
            if (fetch_address_ff == dmc_pkg::ADDR_LAST) begin
               fetch_address_in = dmc_pkg::ADDR_WRAP;
            end else begin
               fetch_address_in = fetch_address_ff + 16'd1;
            end
            if (bytes_left_ff != 12'd0) begin
               bytes_left_in = bytes_left_ff - 12'd1;
               if (bytes_left_in == 12'd0) begin
                  if (loop_mode_ff) begin
                     fetch_address_in = start_address_ff;
                     bytes_left_in    = start_length_ff;
                  end else if (irq_enabled_ff) begin
                     irq_pending_in = 1'b1;
                  end
               end
            end
         end
         dmc_pkg::OP_IRQ_ACK: begin
            irq_pending_in = 1'b0;
         end
         dmc_pkg::OP_ENABLE: begin
            channel_on_in = item.enable_bit;
            if (item.enable_bit) begin
               if (bytes_left_ff == 12'd0) begin
                  fetch_address_in = start_address_ff;
                  bytes_left_in    = start_length_ff;
               end
            end else begin
               bytes_left_in = 12'd0;
            end
         end
         default: begin
         end
      endcase

      result.level_out   = level_in;
      result.irq_out     = irq_pending_in;
      result.dma_request = fetch_pending_in;
      result.dma_address = pending_address_in;
      result.read_data   = read_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_enabled_ff     <= 1'b0;
         loop_mode_ff       <= 1'b0;
         period_value_ff    <= dmc_pkg::PERIOD_RESET;
         period_count_ff    <= dmc_pkg::PERIOD_RESET;
         start_address_ff   <= dmc_pkg::ADDR_BASE;
         start_length_ff    <= 12'd0;
         fetch_address_ff   <= dmc_pkg::ADDR_BASE;
         bytes_left_ff      <= 12'd0;
         buffer_byte_ff     <= 8'd0;
         buffer_empty_ff    <= 1'b1;
         shift_bits_ff      <= 8'd0;
         bits_left_ff       <= dmc_pkg::BITS_PER_BYTE;
         level_ff           <= 7'd0;
         fetch_pending_ff   <= 1'b0;
         pending_address_ff <= 16'd0;
         channel_on_ff      <= 1'b0;
         irq_pending_ff     <= 1'b0;
         silent_ff          <= 1'b1;
      end else if (step) begin
         irq_enabled_ff     <= irq_enabled_in;
         loop_mode_ff       <= loop_mode_in;
         period_value_ff    <= period_value_in;
         period_count_ff    <= period_count_in;
         start_address_ff   <= start_address_in;
         start_length_ff    <= start_length_in;
         fetch_address_ff   <= fetch_address_in;
         bytes_left_ff      <= bytes_left_in;
         buffer_byte_ff     <= buffer_byte_in;
         buffer_empty_ff    <= buffer_empty_in;
         shift_bits_ff      <= shift_bits_in;
         bits_left_ff       <= bits_left_in;
         level_ff           <= level_in;
         fetch_pending_ff   <= fetch_pending_in;
         pending_address_ff <= pending_address_in;
         channel_on_ff      <= channel_on_in;
         irq_pending_ff     <= irq_pending_in;
         silent_ff          <= silent_in;
      end
   end

   logic bits_left_ok;
   logic dma_step;
   logic off_step;
   assign bits_left_ok = bits_left_ff != 4'd0 && bits_left_ff <= dmc_pkg::BITS_PER_BYTE;
   assign dma_step     = step && item.opcode == dmc_pkg::OP_DMA_DATA;
   assign off_step     = step && item.opcode == dmc_pkg::OP_ENABLE && !item.enable_bit;

   `DMC_ASSERT_NOW(a_bits_left_range, clock, reset, 1'b1, bits_left_ok)
   `DMC_ASSERT_NEXT(a_dma_fills_buffer, clock, reset, dma_step, !fetch_pending_ff && !buffer_empty_ff)
   `DMC_ASSERT_NEXT(a_disable_clears, clock, reset, off_step, !channel_on_ff && ~|bytes_left_ff)
   `DMC_ASSERT_NEXT(a_no_irq_when_masked, clock, reset, step && !irq_enabled_in, !irq_pending_ff)

endmodule

`default_nettype wire

// ----- rtl/delta_modulation_sample_channel.sv -----
// Delta-modulation sample channel top level: input register, state update, result register.
// A request is registered in the input register on transfer; when the core steps it, its response
// is registered in the result register and offered on rsp, so a full result register can delay it.
// One request per cycle is sustained while responses are taken; the core's state update sets this.
// A full response register that rsp does not take stalls the input register, which in turn drops req.ready.
// Synchronous reset returns all channel state to its power-up values and empties both stages.
// Depends on dmc_pkg, dmc_req_if, dmc_rsp_if and dmc_core.
`default_nettype none

module delta_modulation_sample_channel (
   input  wire logic clock,
   input  wire logic reset,
   dmc_req_if.sink   req,
   dmc_rsp_if.source rsp
);

   logic                  stage_valid_ff;
   dmc_pkg::req_item_type stage_item_ff;
   logic                  rsp_valid_ff;
   dmc_pkg::rsp_item_type rsp_item_ff;
   dmc_pkg::rsp_item_type core_result;
   logic                  step;

   assign step      = stage_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || step;

   dmc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (stage_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req.ready) begin
            stage_valid_ff <= req.valid;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req.valid && req.ready) begin
         stage_item_ff.opcode      <= dmc_pkg::opcode_type'(req.opcode);
         stage_item_ff.reg_select  <= req.reg_select;
         stage_item_ff.write_value <= req.write_value;
         stage_item_ff.dma_data    <= req.dma_data;
         stage_item_ff.enable_bit  <= req.enable_bit;
      end
      if (step) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.level_out   = rsp_item_ff.level_out;
   assign rsp.irq_out     = rsp_item_ff.irq_out;
   assign rsp.dma_request = rsp_item_ff.dma_request;
   assign rsp.dma_address = rsp_item_ff.dma_address;
   assign rsp.read_data   = rsp_item_ff.read_data;

endmodule

`default_nettype wire
